### hw/rtl/srtc_pkg.sv
// Package for the scaled rectangle transform and clip block.
// Holds coordinate widths, register indexes and the queue entry types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srtc_pkg;
    localparam int CoordW = 32;
    localparam int FracB  = 16;
    localparam int ScaleW = CoordW - 1;
    localparam int AddrW  = 5;
    localparam int QDepth = 8;
    localparam int QPtrW  = 3;
    // Bits that a division produces: integer part plus fraction.
    localparam int QuotW  = CoordW + 1 + FracB;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [ScaleW-1:0] scale_t;

    typedef enum logic [2:0] {
        REG_X_SCALE  = 3'd0,
        REG_Y_SCALE  = 3'd1,
        REG_X_OFFSET = 3'd2,
        REG_Y_OFFSET = 3'd3,
        REG_CLIP_L   = 3'd4,
        REG_CLIP_R   = 3'd5,
        REG_CLIP_T   = 3'd6,
        REG_CLIP_B   = 3'd7
    } reg_idx_t;

    // One classified rectangle: cull mark, clamp marks, mapped edges and source edges.
    typedef struct packed {
        logic          culled;
        logic [3:0]    clamp;
        coord_t [3:0]  dst;
        coord_t [3:0]  src;
    } rect_t;

    // One step of a restoring divide of a 33-bit numerator magnitude
    // widened by FracB zero bits.
    function automatic logic [CoordW:0] div_step_rem(
        input logic [CoordW:0] rem,
        input logic            bit_in,
        input scale_t          s
    );
        logic [CoordW+1:0] r2;
        r2 = {rem, bit_in};
        if (r2 >= {3'b000, s})
            r2 = r2 - {3'b000, s};
        return r2[CoordW:0];
    endfunction

    function automatic coord_t sat_coord(input logic signed [CoordW+1:0] v);
        if (v > $signed({3'b000, {(CoordW-1){1'b1}}}))
            return {1'b0, {(CoordW-1){1'b1}}};
        if (v < $signed({3'b111, {(CoordW-1){1'b0}}}))
            return {1'b1, {(CoordW-1){1'b0}}};
        return v[CoordW-1:0];
    endfunction
endpackage
`default_nettype wire

### hw/rtl/scaled_rect_transform_clip.sv
// Top level of the scaled rectangle transform and clip block.
// Depends on srtc_pkg, srtc_front, srtc_queue, srtc_back.
//
// Usage:
//  - Input channel: push/full. Each beat is one source rectangle (four
//    signed Q16.16 edges). Accepted when push && !full.
//  - Result channel: empty/pop. The oldest result sits on the result ports
//    while empty is low; it leaves on pop && !empty.
//  - Config: APB-style, 32-bit registers at 4*index, pready tied high.
//    Write only while idle. A zero scale is stored as 1.
//  - Throughput: one rectangle per cycle sustained while results are popped.
//  - Path: forward mapping and clamping in the front stages, then the
//    queue, then the divide pipeline (numerator setup, then one quotient
//    bit a stage), and an output register that holds the result.
//  - Stall: when pop is held low the divide pipeline freezes, the middle
//    queue fills, and full rises while the front still has room to drain
//    its three in-flight beats into the queue.
//  - Reset: all pipelines empty; scales 1.0, offsets and clip window 0.
`timescale 1ns / 1ps
`default_nettype none
module scaled_rect_transform_clip (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire srtc_pkg::coord_t     src_left,
    input  wire srtc_pkg::coord_t     src_right,
    input  wire srtc_pkg::coord_t     src_top,
    input  wire srtc_pkg::coord_t     src_bottom,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      culled,
    output srtc_pkg::coord_t          dst_left,
    output srtc_pkg::coord_t          dst_right,
    output srtc_pkg::coord_t          dst_top,
    output srtc_pkg::coord_t          dst_bottom,
    output srtc_pkg::coord_t          out_src_left,
    output srtc_pkg::coord_t          out_src_right,
    output srtc_pkg::coord_t          out_src_top,
    output srtc_pkg::coord_t          out_src_bottom,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [srtc_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import srtc_pkg::*;

    scale_t       x_scale_reg, y_scale_reg;
    coord_t       x_offset_reg, y_offset_reg;
    coord_t [3:0] clip_reg;
    logic         wr;
    reg_idx_t     idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg  <= ScaleW'(1 << FracB);
            y_scale_reg  <= ScaleW'(1 << FracB);
            x_offset_reg <= '0;
            y_offset_reg <= '0;
            clip_reg     <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_X_SCALE:  x_scale_reg  <= (pwdata[ScaleW-1:0] == '0) ? ScaleW'(1)
                                                : pwdata[ScaleW-1:0];
                REG_Y_SCALE:  y_scale_reg  <= (pwdata[ScaleW-1:0] == '0) ? ScaleW'(1)
                                                : pwdata[ScaleW-1:0];
                REG_X_OFFSET: x_offset_reg <= pwdata;
                REG_Y_OFFSET: y_offset_reg <= pwdata;
                REG_CLIP_L:   clip_reg[0]  <= pwdata;
                REG_CLIP_R:   clip_reg[1]  <= pwdata;
                REG_CLIP_T:   clip_reg[2]  <= pwdata;
                REG_CLIP_B:   clip_reg[3]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_SCALE:  prdata = {1'b0, x_scale_reg};
            REG_Y_SCALE:  prdata = {1'b0, y_scale_reg};
            REG_X_OFFSET: prdata = x_offset_reg;
            REG_Y_OFFSET: prdata = y_offset_reg;
            REG_CLIP_L:   prdata = clip_reg[0];
            REG_CLIP_R:   prdata = clip_reg[1];
            REG_CLIP_T:   prdata = clip_reg[2];
            REG_CLIP_B:   prdata = clip_reg[3];
            default:      prdata = '0;
        endcase
    end

    // Front end
    logic         acc;
    logic         f_valid;
    rect_t        f_rect;
    coord_t [3:0] in_src;

    assign acc    = push && !full;
    assign in_src = {src_bottom, src_top, src_right, src_left};

    srtc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_src(in_src),
        .x_scale(x_scale_reg), .y_scale(y_scale_reg),
        .x_offset(x_offset_reg), .y_offset(y_offset_reg), .clip(clip_reg),
        .out_valid(f_valid), .out_rect(f_rect)
    );

    // Middle queue. The front has 3 beats in flight and cannot stall, so
    // full rises once queued plus in-flight beats reach the queue depth.
    logic            q_ne, q_rd;
    rect_t           q_data;
    logic [QPtrW:0]  q_cnt;
    logic [2:0]      inflight;
    logic            b_stall, b_valid;
    rect_t           b_rect;

    srtc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_rect),
        .rd_en(q_rd), .rd_data(q_data), .not_empty(q_ne), .count(q_cnt)
    );

    // Beats headed for the output register but not yet there, counted across
    // front, queue and divide pipeline is too deep; instead the queue gates.
    // The back end stalls only on a valid last beat and an unpopped result.
    logic out_v_reg;
    rect_t out_rect_reg;

    assign b_stall = out_v_reg && b_valid && !pop;
    assign q_rd    = q_ne && !b_stall;

    // Outstanding front beats: those in the three front stages.
    logic [2:0] fr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_reg <= '0;
        else
            fr_reg <= {fr_reg[1:0], acc};
    end
    assign inflight = 3'(fr_reg[0]) + 3'(fr_reg[1]) + 3'(fr_reg[2]);
    assign full = ((QPtrW+2)'(q_cnt) + (QPtrW+2)'(inflight)) >= (QPtrW+2)'(QDepth);

    srtc_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_rd), .in_rect(q_data),
        .stall(b_stall), .out_valid(b_valid), .out_rect(b_rect),
        .x_scale(x_scale_reg), .y_scale(y_scale_reg),
        .x_offset(x_offset_reg), .y_offset(y_offset_reg)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (!out_v_reg || pop)
            out_v_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if ((!out_v_reg || pop) && b_valid)
            out_rect_reg <= b_rect;
    end

    assign empty          = !out_v_reg;
    assign culled         = out_rect_reg.culled;
    assign dst_left       = out_rect_reg.dst[0];
    assign dst_right      = out_rect_reg.dst[1];
    assign dst_top        = out_rect_reg.dst[2];
    assign dst_bottom     = out_rect_reg.dst[3];
    assign out_src_left   = out_rect_reg.src[0];
    assign out_src_right  = out_rect_reg.src[1];
    assign out_src_top    = out_rect_reg.src[2];
    assign out_src_bottom = out_rect_reg.src[3];

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (q_cnt + inflight) >= QDepth) else $error("full without cause");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !pop |=> out_v_reg && $stable(out_rect_reg))
        else $error("result changed while waiting");
    a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && culled |-> dst_left == '0 && dst_right == '0)
        else $error("culled result with nonzero destination");
endmodule
`default_nettype wire

### hw/rtl/srtc_front.sv
// Front end: forward-maps the left, right, top and bottom edges (pipelined multiply), clamps and culls.
// Depends on srtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srtc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire srtc_pkg::coord_t [3:0] in_src,
    input  wire srtc_pkg::scale_t     x_scale,
    input  wire srtc_pkg::scale_t     y_scale,
    input  wire srtc_pkg::coord_t     x_offset,
    input  wire srtc_pkg::coord_t     y_offset,
    input  wire srtc_pkg::coord_t [3:0] clip,
    output logic                      out_valid,
    output srtc_pkg::rect_t           out_rect
);
    import srtc_pkg::*;

    // Stage 1: product magnitude.
    logic          s1_valid_reg;
    logic [3:0]    s1_neg_reg;
    logic [2*CoordW-1:0] s1_prod_reg [4];
    coord_t [3:0]  s1_src_reg;
    // Stage 2: saturated scaled value plus offset.
    logic          s2_valid_reg;
    coord_t [3:0]  s2_dst_reg;
    coord_t [3:0]  s2_src_reg;
    // Stage 3: classified rectangle.
    logic          s3_valid_reg;
    rect_t         s3_rect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [CoordW-1:0] mag;
            mag = in_src[i][CoordW-1] ? CoordW'(-in_src[i]) : in_src[i];
            s1_neg_reg[i]  <= in_src[i][CoordW-1];
            s1_prod_reg[i] <= {{CoordW{1'b0}}, mag} *
                              {{(CoordW+1){1'b0}}, (i < 2) ? x_scale : y_scale};
        end
        s1_src_reg <= in_src;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [2*CoordW-1:0] m;
            logic [CoordW:0]     sc;
            logic                over;
            m    = s1_prod_reg[i] >> FracB;
            over = |m[2*CoordW-1:CoordW-1];
            if (s1_neg_reg[i])
                sc = (over || m[CoordW-1:0] > {1'b1, {(CoordW-1){1'b0}}})
                     ? {2'b11, {(CoordW-1){1'b0}}}
                     : (CoordW+1)'(-{1'b0, m[CoordW-1:0]});
            else
                sc = over ? {2'b00, {(CoordW-1){1'b1}}} : {1'b0, m[CoordW-1:0]};
            s2_dst_reg[i] <= sat_coord($signed({sc[CoordW], sc}) +
                ((CoordW+2)'($signed((i < 2) ? x_offset : y_offset))));
        end
        s2_src_reg <= s1_src_reg;
    end

    always_ff @(posedge clk)
    begin
        logic cull;
        cull = (clip[0] >= s2_dst_reg[1]) || (clip[1] <= s2_dst_reg[0]) ||
               (clip[2] >= s2_dst_reg[3]) || (clip[3] <= s2_dst_reg[2]);
        s3_rect_reg.culled <= cull;
        s3_rect_reg.src    <= s2_src_reg;
        s3_rect_reg.clamp[0] <= !cull && (clip[0] > s2_dst_reg[0]);
        s3_rect_reg.clamp[1] <= !cull && (clip[1] < s2_dst_reg[1]);
        s3_rect_reg.clamp[2] <= !cull && (clip[2] > s2_dst_reg[2]);
        s3_rect_reg.clamp[3] <= !cull && (clip[3] < s2_dst_reg[3]);
        for (int i = 0; i < 4; i++)
        begin
            logic c;
            c = (i == 0 || i == 2) ? (clip[i] > s2_dst_reg[i]) : (clip[i] < s2_dst_reg[i]);
            s3_rect_reg.dst[i] <= cull ? '0 : (c ? clip[i] : s2_dst_reg[i]);
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_rect  = s3_rect_reg;

    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> ##2 out_valid) else $error("front pipeline lost a beat");
    a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rect.culled |-> out_rect.dst == '0 && out_rect.clamp == '0)
        else $error("culled rectangle with nonzero destination");
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rect.clamp[0] |-> out_rect.dst[0] == $past(clip[0]))
        else $error("left clamp mismatch");
endmodule
`default_nettype wire

### hw/rtl/srtc_queue.sv
// Short queue between front and back end, with a count output for almost-full.
// Depends on srtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srtc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire srtc_pkg::rect_t wr_data,
    input  wire logic            rd_en,
    output srtc_pkg::rect_t      rd_data,
    output logic                 not_empty,
    output logic [srtc_pkg::QPtrW:0] count
);
    import srtc_pkg::*;

    rect_t              mem [QDepth];
    logic [QPtrW-1:0]   wp_reg, rp_reg;
    logic [QPtrW:0]     cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(wr_en) - (QPtrW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    assign rd_data   = mem[rp_reg];
    assign not_empty = cnt_reg != '0;
    assign count     = cnt_reg;

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && !rd_en && cnt_reg == (QPtrW+1)'(QDepth))) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> cnt_reg != '0) else $error("queue underflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == (QPtrW+1)'(QDepth)) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with count");
endmodule
`default_nettype wire

### hw/rtl/srtc_back.sv
// Back end: pipelined inverse map of clamped edges, one quotient bit per stage.
// Depends on srtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srtc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire srtc_pkg::rect_t in_rect,
    input  wire logic            stall,
    output logic                 out_valid,
    output srtc_pkg::rect_t      out_rect,
    input  wire srtc_pkg::scale_t x_scale,
    input  wire srtc_pkg::scale_t y_scale,
    input  wire srtc_pkg::coord_t x_offset,
    input  wire srtc_pkg::coord_t y_offset
);
    import srtc_pkg::*;

    localparam int NSt = QuotW + 1;

    // Stage 0 forms numerator magnitude; stages 1..QuotW each retire one bit.
    logic             v_reg   [NSt];
    rect_t            r_reg   [NSt];
    logic [3:0]       neg_reg [NSt];
    logic [CoordW:0]  num_reg [NSt][4];
    logic [CoordW:0]  rem_reg [NSt][4];
    logic [QuotW-1:0] q_reg   [NSt][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int k = 0; k < NSt; k++)
                v_reg[k] <= 1'b0;
        else if (!stall)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < NSt; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            r_reg[0] <= in_rect;
            for (int i = 0; i < 4; i++)
            begin
                logic signed [CoordW:0] n;
                n = $signed({in_rect.dst[i][CoordW-1], in_rect.dst[i]}) -
                    $signed({(i < 2) ? x_offset[CoordW-1] : y_offset[CoordW-1],
                             (i < 2) ? x_offset : y_offset});
                neg_reg[0][i]    <= n[CoordW];
                num_reg[0][i]    <= n[CoordW] ? (CoordW+1)'(-n) : n;
                rem_reg[0][i]    <= '0;
                q_reg[0][i]      <= '0;
            end
            for (int k = 1; k < NSt; k++)
            begin
                r_reg[k]   <= r_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                for (int i = 0; i < 4; i++)
                begin
                    logic        b;
                    logic [CoordW:0] r;
                    scale_t      s;
                    logic [CoordW+1:0] r2;
                    s  = (i < 2) ? x_scale : y_scale;
                    b  = (k <= CoordW + 1) ? num_reg[k-1][i][CoordW + 1 - k] : 1'b0;
                    r  = div_step_rem(rem_reg[k-1][i], b, s);
                    r2 = {rem_reg[k-1][i], b};
                    num_reg[k][i] <= num_reg[k-1][i];
                    rem_reg[k][i] <= r;
                    q_reg[k][i]   <= {q_reg[k-1][i][QuotW-2:0], r2 >= {3'b000, s}};
                end
            end
        end
    end

    always_comb
    begin
        out_valid = v_reg[NSt-1];
        out_rect  = r_reg[NSt-1];
        for (int i = 0; i < 4; i++)
        begin
            logic [QuotW-1:0] q;
            logic over;
            q    = q_reg[NSt-1][i];
            over = |q[QuotW-1:CoordW-1];
            if (r_reg[NSt-1].clamp[i])
            begin
                if (neg_reg[NSt-1][i])
                    out_rect.src[i] = (over && q[QuotW-1:0] != QuotW'({1'b1, {(CoordW-1){1'b0}}}))
                        ? {1'b1, {(CoordW-1){1'b0}}} : CoordW'(-q);
                else
                    out_rect.src[i] = over ? {1'b0, {(CoordW-1){1'b1}}} : q[CoordW-1:0];
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall && out_valid |=> out_valid) else $error("back end dropped a stalled beat");
    a_cull: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rect.culled |-> out_rect.src == r_reg[NSt-1].src)
        else $error("culled source changed");
    a_scale: assert property (@(posedge clk) disable iff (!rst_n)
        x_scale != '0 && y_scale != '0) else $error("zero scale reached divider");
endmodule
`default_nettype wire
